// File: design/phase_min_node_macros.svh
// Assertion macros for the phase minimum node.
`ifndef PHASE_MIN_NODE_MACROS_SVH
`define PHASE_MIN_NODE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define PMN_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pmn assertion failed");
// Next-cycle implication, checked out of reset.
`define PMN_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pmn assertion failed");
`else
`define PMN_ASSERT_IMP(label, ante, cons)
`define PMN_ASSERT_NXT(label, ante, cons)
`endif

`endif

// File: design/pmn_pkg.sv
// Types, constants and helper functions shared by the phase minimum node.
`timescale 1ns / 1ps
package pmn_pkg;

    localparam int MAX_IN_NEIGHBOURS  = 4;
    localparam int MAX_OUT_NEIGHBOURS = 4;
    localparam int PACKED_SLOTS       = 4;

    localparam int IN_CNT_W  = $clog2(MAX_IN_NEIGHBOURS + 1);
    localparam int OUT_CNT_W = $clog2(MAX_OUT_NEIGHBOURS + 1);
    localparam int OUT_IDX_W = (MAX_OUT_NEIGHBOURS > 1) ? $clog2(MAX_OUT_NEIGHBOURS) : 1;

    localparam int ID_W    = 8;
    localparam int VAL_W   = 32;
    localparam int ROUND_W = 8;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int REG_IDX_W = 3;

    // Input action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_RECV  = 1'b1;

    // Result kind codes
    localparam logic KIND_SEND   = 1'b0;
    localparam logic KIND_DECIDE = 1'b1;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_IN_COUNT  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OUT_COUNT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_IN_IDS    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OUT_IDS   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OWN_VALUE = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ROUNDS    = 3'd5;

    typedef struct packed {
        logic                    action;
        logic [ID_W-1:0]         source;
        logic signed [VAL_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic                    kind;
        logic [ID_W-1:0]         dest;
        logic signed [VAL_W-1:0] result_value;
        logic                    last;
    } t_out_word;

    typedef struct packed {
        logic [2:0]              in_count;
        logic [2:0]              out_count;
        logic [31:0]             in_ids;
        logic [31:0]             out_ids;
        logic signed [VAL_W-1:0] own_value;
        logic [ROUND_W-1:0]      rounds;
    } t_cfg;

    // One item's results handed from the update logic to the emitter
    typedef struct packed {
        logic                    load;
        logic                    dec;
        logic [OUT_CNT_W-1:0]    nsend;
        logic signed [VAL_W-1:0] val;
    } t_batch;

    typedef logic [MAX_IN_NEIGHBOURS-1:0][ROUND_W-1:0] t_cnt_arr;

    // Pick one 8-bit id out of a packed register; slots past the register read 0
    function automatic logic [ID_W-1:0] slot_id(input logic [31:0] ids, input int slot);
        logic [ID_W-1:0] id;
        id = '0;
        if (slot < PACKED_SLOTS) begin
            id = ids[ID_W*slot +: ID_W];
        end
        return id;
    endfunction

    function automatic logic [IN_CNT_W-1:0] eff_in(input logic [2:0] cnt);
        logic [IN_CNT_W-1:0] n;
        if (cnt == 3'd0) begin
            n = IN_CNT_W'(1);
        end else if (int'(cnt) > MAX_IN_NEIGHBOURS) begin
            n = IN_CNT_W'(MAX_IN_NEIGHBOURS);
        end else begin
            n = IN_CNT_W'(cnt);
        end
        return n;
    endfunction

    function automatic logic [OUT_CNT_W-1:0] eff_out(input logic [2:0] cnt);
        logic [OUT_CNT_W-1:0] n;
        if (int'(cnt) > MAX_OUT_NEIGHBOURS) begin
            n = OUT_CNT_W'(MAX_OUT_NEIGHBOURS);
        end else begin
            n = OUT_CNT_W'(cnt);
        end
        return n;
    endfunction

    function automatic logic [ROUND_W-1:0] eff_rounds(input logic [ROUND_W-1:0] r);
        return (r == '0) ? ROUND_W'(1) : r;
    endfunction

    // True when every used in-neighbour counter is at least lim
    function automatic logic all_ge(input t_cnt_arr cnts, input logic [IN_CNT_W-1:0] ni,
                                    input logic [ROUND_W-1:0] lim);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < MAX_IN_NEIGHBOURS; i++) begin
            if (i < int'(ni) && cnts[i] < lim) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

// File: design/pmn_regs.sv
// Configuration register file with an APB-style access port.
`timescale 1ns / 1ps
module pmn_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pmn_pkg::ADDR_W-1:0]  paddr,
    input  logic [pmn_pkg::DATA_W-1:0]  pwdata,
    output logic [pmn_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output pmn_pkg::t_cfg               o_cfg
);
    import pmn_pkg::*;

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.in_count  <= 3'd1;
            r_cfg.out_count <= 3'd1;
            r_cfg.in_ids    <= '0;
            r_cfg.out_ids   <= '0;
            r_cfg.own_value <= '0;
            r_cfg.rounds    <= ROUND_W'(5);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_IN_COUNT:  r_cfg.in_count  <= pwdata[2:0];
                REG_OUT_COUNT: r_cfg.out_count <= pwdata[2:0];
                REG_IN_IDS:    r_cfg.in_ids    <= pwdata;
                REG_OUT_IDS:   r_cfg.out_ids   <= pwdata;
                REG_OWN_VALUE: r_cfg.own_value <= pwdata;
                REG_ROUNDS:    r_cfg.rounds    <= pwdata[ROUND_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (reg_idx)
            REG_IN_COUNT:  prdata = DATA_W'(r_cfg.in_count);
            REG_OUT_COUNT: prdata = DATA_W'(r_cfg.out_count);
            REG_IN_IDS:    prdata = r_cfg.in_ids;
            REG_OUT_IDS:   prdata = r_cfg.out_ids;
            REG_OWN_VALUE: prdata = r_cfg.own_value;
            REG_ROUNDS:    prdata = DATA_W'(r_cfg.rounds);
            default:       prdata = '0;
        endcase
    end

endmodule

// File: design/pmn_core.sv
// Input register, node state and the one-pass update for each word.
`timescale 1ns / 1ps
module pmn_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pmn_pkg::t_in_word i_in_word,
    input  pmn_pkg::t_cfg     i_cfg,
    input  logic              i_emit_free,
    output pmn_pkg::t_batch   o_batch
);
    import pmn_pkg::*;

    logic                    r_in_valid;
    t_in_word                r_in;

    t_cnt_arr                r_cnt, n_cnt;
    logic [ROUND_W-1:0]      r_round, n_round;
    logic signed [VAL_W-1:0] r_min, n_min;
    logic                    r_dec, n_dec;

    logic                    fire;
    logic                    skip;
    logic                    emit_dec;
    logic                    send;
    logic [ROUND_W-1:0]      base_round;
    logic [ROUND_W-1:0]      rnd;
    logic [IN_CNT_W-1:0]     ni;
    logic [OUT_CNT_W-1:0]    no_out;

    assign rnd    = eff_rounds(i_cfg.rounds);
    assign ni     = eff_in(i_cfg.in_count);
    assign no_out = eff_out(i_cfg.out_count);

    assign fire       = r_in_valid && i_emit_free;
    assign o_in_stall = r_in_valid && !i_emit_free;

    // Capture the next word whenever the held one moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_word;
        end
    end

    // Work out the new state and the results of the held word
    always_comb begin
        n_cnt      = r_cnt;
        n_round    = r_round;
        n_min      = r_min;
        n_dec      = r_dec;
        skip       = 1'b0;
        emit_dec   = 1'b0;
        if (r_in.action == ACT_START) begin
            n_cnt   = '0;
            n_round = '0;
            n_dec   = 1'b0;
            n_min   = i_cfg.own_value;
        end else if (all_ge(r_cnt, ni, rnd) && r_round >= rnd) begin
            // node already finished: drop the word
            skip = 1'b1;
        end else begin
            if (r_in.value < r_min) begin
                n_min = r_in.value;
            end
            for (int i = 0; i < MAX_IN_NEIGHBOURS; i++) begin
                if (i < int'(ni) && slot_id(i_cfg.in_ids, i) == r_in.source
                    && r_cnt[i] < rnd) begin
                    n_cnt[i] = r_cnt[i] + ROUND_W'(1);
                end
            end
            if (!r_dec && all_ge(n_cnt, ni, rnd)) begin
                emit_dec = 1'b1;
                n_dec    = 1'b1;
            end
        end
        base_round = n_round;
        send = !skip && base_round < rnd && all_ge(n_cnt, ni, base_round);
        if (send) begin
            n_round = base_round + ROUND_W'(1);
        end
    end

    // Advance the node state on each word taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_round <= '0;
            r_min   <= '0;
            r_dec   <= 1'b0;
        end else if (fire) begin
            r_cnt   <= n_cnt;
            r_round <= n_round;
            r_min   <= n_min;
            r_dec   <= n_dec;
        end
    end

    // Hand the results to the emitter
    always_comb begin
        o_batch.dec   = emit_dec;
        o_batch.nsend = send ? no_out : '0;
        o_batch.val   = n_min;
        o_batch.load  = fire && (emit_dec || (send && no_out != '0));
    end

endmodule

// File: design/pmn_emit.sv
// Result register that plays out one word's decision and sends in order.
`timescale 1ns / 1ps
module pmn_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pmn_pkg::t_batch    i_batch,
    input  pmn_pkg::t_cfg      i_cfg,
    output logic               o_free,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pmn_pkg::t_out_word o_out_word
);
    import pmn_pkg::*;

    logic                    r_dec;
    logic [OUT_CNT_W-1:0]    r_left;
    logic [OUT_IDX_W-1:0]    r_idx;
    logic signed [VAL_W-1:0] r_val;

    logic                    take;
    logic                    last;

    assign o_out_valid = r_dec || (r_left != '0);
    assign take        = o_out_valid && !i_out_stall;
    assign last        = r_dec ? (r_left == '0) : (r_left == OUT_CNT_W'(1));
    assign o_free      = !o_out_valid || (take && last);

    // Decision first, then sends in slot order
    always_comb begin
        o_out_word.kind         = r_dec ? KIND_DECIDE : KIND_SEND;
        o_out_word.dest         = r_dec ? '0 : slot_id(i_cfg.out_ids, int'(r_idx));
        o_out_word.result_value = r_val;
        o_out_word.last         = last;
    end

    // Load a new batch or step through the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec  <= 1'b0;
            r_left <= '0;
            r_idx  <= '0;
        end else if (i_batch.load) begin
            r_dec  <= i_batch.dec;
            r_left <= i_batch.nsend;
            r_idx  <= '0;
        end else if (take) begin
            if (r_dec) begin
                r_dec <= 1'b0;
            end else begin
                r_left <= r_left - OUT_CNT_W'(1);
                r_idx  <= r_idx + OUT_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_batch.load) begin
            r_val <= i_batch.val;
        end
    end

endmodule

// File: design/phase_min_node.sv
// Top level of one phase-algorithm minimum node.
//
//  channel  direction  valid        stall        word
//  in       input      i_in_valid   o_in_stall   i_in_word  (action, source, value)
//  out      output     o_out_valid  i_out_stall  o_out_word (kind, dest, result_value, last)
//  cfg      input      APB psel/penable/pwrite, paddr, pwdata, prdata, pready
//
// A word is registered, then updated against the node state and its
// results are loaded into the result register. A word that gives at most one result
// moves on every cycle while the output does not stall; one that gives n results (up to
// five: a decision and four sends) holds the result register while the single result port
// plays them out one by one. Reset is synchronous; there is no clearing pass.
// A stall on the output holds the result register and, once the held word waits, the input.
`timescale 1ns / 1ps
module phase_min_node (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  pmn_pkg::t_in_word           i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output pmn_pkg::t_out_word          o_out_word,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pmn_pkg::ADDR_W-1:0]  paddr,
    input  logic [pmn_pkg::DATA_W-1:0]  pwdata,
    output logic [pmn_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import pmn_pkg::*;

`include "phase_min_node_macros.svh"

    t_cfg   cfg;
    t_batch batch;
    logic   emit_free;

    pmn_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pmn_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .i_cfg       (cfg),
        .i_emit_free (emit_free),
        .o_batch     (batch)
    );

    pmn_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_batch     (batch),
        .i_cfg       (cfg),
        .o_free      (emit_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // A decision always carries a zero destination
    `PMN_ASSERT_IMP(a_decide_dest_zero, o_out_valid && o_out_word.kind == KIND_DECIDE, o_out_word.dest == '0)
    // A batch taken before its last word keeps the output busy
    `PMN_ASSERT_NXT(a_batch_continues, o_out_valid && !i_out_stall && !o_out_word.last, o_out_valid)
    // A new batch is only loaded into a free result register
    `PMN_ASSERT_IMP(a_load_when_free, batch.load, emit_free)

endmodule
